// ----- rtl/rrrv_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rrrv_pkg
// Types and constants of the rolling regression residual volatility core.
// ---------------------------------------------------------------------------
// ---------------------------------------------------------------------------
package rrrv_pkg;

  localparam int unsigned VolW    = 31;
  localparam int unsigned FloorW  = 20;
  localparam int unsigned CountW  = 7;
  localparam int unsigned QuotW   = 62;
  localparam int unsigned RootIt  = 32;
  localparam int unsigned CfgAddrW = 4;

  localparam logic [CfgAddrW-1:0] ADDR_WINDOW_LENGTH   = 4'h0;
  localparam logic [CfgAddrW-1:0] ADDR_MIN_VALID_COUNT = 4'h4;
  localparam logic [CfgAddrW-1:0] ADDR_VARIANCE_FLOOR  = 4'h8;

  localparam logic [CountW-1:0] WINDOW_LENGTH_RST   = 7'd20;
  localparam logic [CountW-1:0] MIN_VALID_COUNT_RST = 7'd5;
  localparam logic [FloorW-1:0] VARIANCE_FLOOR_RST  = 20'd72;
  localparam logic [CountW-1:0] MIN_COUNT_FLOOR     = 7'd3;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ACC  = 6'b000010,
    ST_BIG  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SQRT = 6'b010000,
    ST_FIN  = 6'b100000
  } state_e;

  typedef enum logic [2:0] {
    BP_LOAD  = 3'b001,
    BP_RUN   = 3'b010,
    BP_STORE = 3'b100
  } big_phase_e;

  typedef enum logic [4:0] {
    AP_READ = 5'b00001,
    AP_XX   = 5'b00010,
    AP_YY   = 5'b00100,
    AP_XY   = 5'b01000,
    AP_NEXT = 5'b10000
  } acc_phase_e;

  typedef enum logic [3:0] {
    BS_NSXX  = 4'd0,
    BS_SXSX  = 4'd1,
    BS_NSYY  = 4'd2,
    BS_SYSY  = 4'd3,
    BS_NSXY  = 4'd4,
    BS_SXSY  = 4'd5,
    BS_NN    = 4'd6,
    BS_FLOOR = 4'd7,
    BS_YYXX  = 4'd8,
    BS_XYXY  = 4'd9,
    BS_DEN   = 4'd10
  } big_step_e;

endpackage

// ----- rtl/rolling_regression_residual_vol_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rolling_regression_residual_vol_core
// Residual standard deviation of a rolling least-squares fit of stock on
// market returns, computed with one shared serial multiplier, a restoring
// divider and a digit-by-digit square root.
// ---------------------------------------------------------------------------
//  channel   dir  tdata / data                          tuser
//  s_axis    in   [VB-1:0] stock, [2VB-1:VB] market      [0] stock_ok, [1] market_ok
//  m_axis    out  [30:0] residual_vol                    [0] vol_ok
//  apb       in   0x0 window_length, 0x4 min_valid_count, 0x8 variance_floor
//
//  one word runs a read and three products per valid day (a read alone for a
//  missing one), up to eleven shift-add products on one wide adder, a 62-step
//  divide and a 32-step root
//  s_axis_tready is high only while idle; a finished word waits in the output
//  register while the next word is accepted
//  rst_ni clears control state and loads the register reset values
// ---------------------------------------------------------------------------
module rolling_regression_residual_vol_core
  import rrrv_pkg::*;
#(
  parameter int unsigned WINDOW_MAX = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // stock_return, market_return
  input  logic [((2*VALUE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // stock_ok, market_ok
  input  logic [1:0]                          s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // residual_vol, zero pad
  output logic [31:0]                         m_axis_tdata,
  // vol_ok
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [CfgAddrW-1:0]                 paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  localparam int unsigned VB   = VALUE_BITS;
  localparam int unsigned AW   = $clog2(WINDOW_MAX);
  localparam int unsigned CW   = $clog2(WINDOW_MAX + 1);
  localparam int unsigned SW   = VB + CW;
  localparam int unsigned QW   = 2 * VB + CW;
  localparam int unsigned PW   = 4 * (VB + CW) + 4;
  localparam int unsigned RW   = PW + QuotW;
  localparam int unsigned MBN  = CW + 1;
  localparam int unsigned MBS  = SW;
  localparam int unsigned MBF  = FloorW + 1;
  localparam int unsigned MBL  = 2 * (VB + CW) + 1;
  localparam int unsigned MBD  = 2 * CW + 1;
  localparam int unsigned CNTW = $clog2(PW);

  // config
  logic [CountW-1:0] window_length_q, min_valid_count_q;
  logic [FloorW-1:0] variance_floor_q;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr)
      ADDR_WINDOW_LENGTH:   prdata = {{(32-CountW){1'b0}}, window_length_q};
      ADDR_MIN_VALID_COUNT: prdata = {{(32-CountW){1'b0}}, min_valid_count_q};
      ADDR_VARIANCE_FLOOR:  prdata = {{(32-FloorW){1'b0}}, variance_floor_q};
      default:              prdata = 32'd0;
    endcase
  end

  // control state
  state_e           state_q;
  acc_phase_e       aph_q;
  big_phase_e       bph_q;
  big_step_e        step_q;
  logic [AW-1:0]    wslot_q, ptr_q;
  logic [CW-1:0]    days_q, win_q, k_q, n_q;
  logic [CNTW-1:0]  cnt_q;
  logic             first_q;
  logic             m_valid_q;

  // datapath
  logic [2*VB:0]            ring_q [WINDOW_MAX];
  logic [2*VB:0]            rd_q;
  logic signed [2*VB-1:0]   prod_q;
  logic signed [SW-1:0]     sx_q, sy_q;
  logic signed [QW-1:0]     sxx_q, syy_q, sxy_q;
  logic [2*CW-1:0]          nn2_q;
  logic [PW-1:0]            a_q, b_q, acc_q, t_q, cxx_q, cyy_q, cxy_q, num_q, den_q;
  logic [RW-1:0]            rem_q, dv_q;
  logic [QuotW-1:0]         q_q;
  logic [63:0]              op_q, res_q, one_q;
  logic [VolW-1:0]          vol_q, m_data_q;
  logic                     vok_q, m_ok_q;

  logic                     s_acc;
  logic signed [VB-1:0]     rx, ry;
  logic                     rok;
  logic [CW-1:0]            days_nx, win_c;
  logic [CountW-1:0]        minc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign rx  = rd_q[2*VB-1:VB];
  assign ry  = rd_q[VB-1:0];
  assign rok = rd_q[2*VB];

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};
  assign m_axis_tuser  = m_ok_q;

  assign days_nx = (32'(days_q) < WINDOW_MAX) ? days_q + CW'(1) : days_q;
  assign minc    = (min_valid_count_q < MIN_COUNT_FLOOR) ? MIN_COUNT_FLOOR : min_valid_count_q;

  always_comb begin
    if (window_length_q == '0) begin
      win_c = CW'(1);
    end else if (32'(window_length_q) > WINDOW_MAX) begin
      win_c = CW'(WINDOW_MAX);
    end else begin
      win_c = CW'(window_length_q);
    end
  end

  // operand select for the shared multiplier
  logic [PW-1:0]   ld_a, ld_bs;
  logic [CNTW-1:0] ld_cnt;
  logic [PW-1:0]   n_ext, sx_ext, sy_ext, sxx_ext, syy_ext, sxy_ext;

  assign n_ext   = {{(PW-CW){1'b0}}, n_q};
  assign sx_ext  = {{(PW-SW){sx_q[SW-1]}}, sx_q};
  assign sy_ext  = {{(PW-SW){sy_q[SW-1]}}, sy_q};
  assign sxx_ext = {{(PW-QW){sxx_q[QW-1]}}, sxx_q};
  assign syy_ext = {{(PW-QW){syy_q[QW-1]}}, syy_q};
  assign sxy_ext = {{(PW-QW){sxy_q[QW-1]}}, sxy_q};

  always_comb begin
    unique case (step_q)
      BS_NSXX: begin
        ld_a = sxx_ext; ld_bs = n_ext << (PW - MBN); ld_cnt = CNTW'(MBN - 1);
      end
      BS_SXSX: begin
        ld_a = sx_ext; ld_bs = sx_ext << (PW - MBS); ld_cnt = CNTW'(MBS - 1);
      end
      BS_NSYY: begin
        ld_a = syy_ext; ld_bs = n_ext << (PW - MBN); ld_cnt = CNTW'(MBN - 1);
      end
      BS_SYSY: begin
        ld_a = sy_ext; ld_bs = sy_ext << (PW - MBS); ld_cnt = CNTW'(MBS - 1);
      end
      BS_NSXY: begin
        ld_a = sxy_ext; ld_bs = n_ext << (PW - MBN); ld_cnt = CNTW'(MBN - 1);
      end
      BS_SXSY: begin
        ld_a = sx_ext; ld_bs = sy_ext << (PW - MBS); ld_cnt = CNTW'(MBS - 1);
      end
      BS_NN: begin
        ld_a = n_ext; ld_bs = n_ext << (PW - MBN); ld_cnt = CNTW'(MBN - 1);
      end
      BS_FLOOR: begin
        ld_a   = t_q;
        ld_bs  = {{(PW-FloorW){1'b0}}, variance_floor_q} << (PW - MBF);
        ld_cnt = CNTW'(MBF - 1);
      end
      BS_YYXX: begin
        ld_a = cyy_q; ld_bs = cxx_q << (PW - MBL); ld_cnt = CNTW'(MBL - 1);
      end
      BS_XYXY: begin
        ld_a = cxy_q; ld_bs = cxy_q << (PW - MBL); ld_cnt = CNTW'(MBL - 1);
      end
      BS_DEN: begin
        ld_a   = cxx_q;
        ld_bs  = {{(PW-2*CW){1'b0}}, nn2_q} << (PW - MBD);
        ld_cnt = CNTW'(MBD - 1);
      end
      default: begin
        ld_a = '0; ld_bs = '0; ld_cnt = '0;
      end
    endcase
  end

  // shared shift-add unit, multiplier bits taken msb first
  logic [PW-1:0] mul_add, mul_nx, diff;
  logic          mul_cin;

  assign mul_add = b_q[PW-1] ? (first_q ? ~a_q : a_q) : '0;
  assign mul_cin = b_q[PW-1] & first_q;
  assign mul_nx  = {acc_q[PW-2:0], 1'b0} + mul_add + {{(PW-1){1'b0}}, mul_cin};
  assign diff    = t_q - acc_q;

  // divider and root steps
  logic [RW-1:0] dvs, num_r, den_r;
  logic          div_ge, sat;
  logic [63:0]   sq_t;
  logic          sq_ge;

  assign dvs    = dv_q >> 1;
  assign div_ge = rem_q >= dvs;
  assign num_r  = {{QuotW{1'b0}}, num_q};
  assign den_r  = {den_q, {QuotW{1'b0}}};
  assign sat    = num_r >= den_r;
  assign sq_t   = res_q + one_q;
  assign sq_ge  = op_q >= sq_t;

  // ring memory
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      ring_q[wslot_q] <= {s_axis_tuser[0] & s_axis_tuser[1],
                          s_axis_tdata[2*VB-1:VB], s_axis_tdata[VB-1:0]};
    end
    rd_q <= ring_q[ptr_q];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q   <= WINDOW_LENGTH_RST;
      min_valid_count_q <= MIN_VALID_COUNT_RST;
      variance_floor_q  <= VARIANCE_FLOOR_RST;
      state_q   <= ST_IDLE;
      aph_q     <= AP_READ;
      bph_q     <= BP_LOAD;
      step_q    <= BS_NSXX;
      wslot_q   <= '0;
      ptr_q     <= '0;
      days_q    <= '0;
      win_q     <= '0;
      k_q       <= '0;
      n_q       <= '0;
      cnt_q     <= '0;
      first_q   <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        unique case (paddr)
          ADDR_WINDOW_LENGTH:   window_length_q   <= pwdata[CountW-1:0];
          ADDR_MIN_VALID_COUNT: min_valid_count_q <= pwdata[CountW-1:0];
          ADDR_VARIANCE_FLOOR:  variance_floor_q  <= pwdata[FloorW-1:0];
          default: ;
        endcase
      end
      if (m_valid_q && m_axis_tready && (state_q != ST_FIN)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_acc) begin
            wslot_q <= (wslot_q == AW'(WINDOW_MAX - 1)) ? '0 : wslot_q + AW'(1);
            days_q  <= days_nx;
            ptr_q   <= wslot_q;
            win_q   <= win_c;
            k_q     <= '0;
            n_q     <= '0;
            aph_q   <= AP_READ;
            state_q <= (days_nx < win_c) ? ST_FIN : ST_ACC;
          end
        end
        ST_ACC: begin
          unique case (aph_q)
            AP_READ: aph_q <= AP_XX;
            AP_XX: begin
              if (rok) begin
                n_q   <= n_q + CW'(1);
                aph_q <= AP_YY;
              end else begin
                aph_q <= AP_NEXT;
              end
            end
            AP_YY: aph_q <= AP_XY;
            AP_XY: aph_q <= AP_NEXT;
            AP_NEXT: begin
              ptr_q <= (ptr_q == '0) ? AW'(WINDOW_MAX - 1) : ptr_q - AW'(1);
              k_q   <= k_q + CW'(1);
              aph_q <= AP_READ;
              if (k_q + CW'(1) == win_q) begin
                step_q  <= BS_NSXX;
                bph_q   <= BP_LOAD;
                state_q <= (32'(n_q) < 32'(minc)) ? ST_FIN : ST_BIG;
              end
            end
            default: aph_q <= AP_READ;
          endcase
        end
        ST_BIG: begin
          unique case (bph_q)
            BP_LOAD: begin
              cnt_q   <= ld_cnt;
              first_q <= 1'b1;
              bph_q   <= BP_RUN;
            end
            BP_RUN: begin
              first_q <= 1'b0;
              cnt_q   <= cnt_q - CNTW'(1);
              if (cnt_q == '0) begin
                bph_q <= BP_STORE;
              end
            end
            BP_STORE: begin
              bph_q <= BP_LOAD;
              if (step_q == BS_FLOOR) begin
                if ($signed(cxx_q) > $signed(acc_q)) begin
                  step_q <= BS_YYXX;
                end else begin
                  first_q <= 1'b1;
                  state_q <= ST_DIV;
                end
              end else if (step_q == BS_DEN) begin
                first_q <= 1'b1;
                state_q <= ST_DIV;
              end else begin
                step_q <= big_step_e'(step_q + 4'd1);
              end
            end
            default: bph_q <= BP_LOAD;
          endcase
        end
        ST_DIV: begin
          if (first_q) begin
            first_q <= 1'b0;
            cnt_q   <= CNTW'(QuotW - 1);
            if (num_q[PW-1] || sat) begin
              state_q <= ST_FIN;
            end
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
            if (cnt_q == '0) begin
              first_q <= 1'b1;
              state_q <= ST_SQRT;
            end
          end
        end
        ST_SQRT: begin
          if (first_q) begin
            first_q <= 1'b0;
            cnt_q   <= CNTW'(RootIt - 1);
          end else begin
            cnt_q <= cnt_q - CNTW'(1);
            if (cnt_q == '0) begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        sx_q  <= '0;
        sy_q  <= '0;
        sxx_q <= '0;
        syy_q <= '0;
        sxy_q <= '0;
        vol_q <= '0;
        vok_q <= 1'b0;
      end
      ST_ACC: begin
        unique case (aph_q)
          AP_XX: begin
            prod_q <= rx * rx;
            if (rok) begin
              sx_q <= sx_q + {{CW{rx[VB-1]}}, rx};
              sy_q <= sy_q + {{CW{ry[VB-1]}}, ry};
            end
          end
          AP_YY: begin
            sxx_q  <= sxx_q + {{CW{prod_q[2*VB-1]}}, prod_q};
            prod_q <= ry * ry;
          end
          AP_XY: begin
            syy_q  <= syy_q + {{CW{prod_q[2*VB-1]}}, prod_q};
            prod_q <= rx * ry;
          end
          AP_NEXT: begin
            if (rok) begin
              sxy_q <= sxy_q + {{CW{prod_q[2*VB-1]}}, prod_q};
            end
            nn2_q <= (2*CW)'(n_q) * (2*CW)'(n_q - CW'(2));
          end
          default: ;
        endcase
      end
      ST_BIG: begin
        unique case (bph_q)
          BP_LOAD: begin
            a_q   <= ld_a;
            b_q   <= ld_bs;
            acc_q <= '0;
          end
          BP_RUN: begin
            acc_q <= mul_nx;
            b_q   <= {b_q[PW-2:0], 1'b0};
          end
          BP_STORE: begin
            unique case (step_q)
              BS_NSXX, BS_NSYY, BS_NSXY, BS_NN, BS_YYXX: t_q <= acc_q;
              BS_SXSX: cxx_q <= diff;
              BS_SYSY: cyy_q <= diff;
              BS_SXSY: cxy_q <= diff;
              BS_FLOOR: begin
                num_q <= cyy_q;
                den_q <= {{(PW-2*CW){1'b0}}, nn2_q};
              end
              BS_XYXY: num_q <= diff;
              BS_DEN:  den_q <= acc_q;
              default: ;
            endcase
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (first_q) begin
          rem_q <= num_r;
          dv_q  <= den_r;
          vok_q <= 1'b1;
          vol_q <= (!num_q[PW-1] && sat) ? {VolW{1'b1}} : '0;
        end else begin
          dv_q <= dvs;
          q_q  <= {q_q[QuotW-2:0], div_ge};
          if (div_ge) begin
            rem_q <= rem_q - dvs;
          end
        end
      end
      ST_SQRT: begin
        if (first_q) begin
          op_q  <= {{(64-QuotW){1'b0}}, q_q};
          res_q <= '0;
          one_q <= 64'd1 << QuotW;
        end else begin
          one_q <= one_q >> 2;
          if (sq_ge) begin
            op_q  <= op_q - sq_t;
            res_q <= (res_q >> 1) + one_q;
          end else begin
            res_q <= res_q >> 1;
          end
          if (cnt_q == '0) begin
            vol_q <= sq_ge ? res_q[VolW:1] + one_q[VolW-1:0] : res_q[VolW:1];
          end
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_q <= vol_q;
          m_ok_q   <= vok_q;
        end
      end
      default: ;
    endcase
  end

endmodule
